>>> design/avsv_pkg.sv
// Shared types, constants and helper functions of the averaging voltmeter.
// Used by every module of the block; depends on nothing else.
package avsv_pkg;

   // Averaging block length
   localparam int SAMPLES_PER_AVERAGE = 10;

   // Field widths
   localparam int CODE_W    = 10;
   localparam int SUM_W     = 14;
   localparam int TALLY_W   = $clog2(SAMPLES_PER_AVERAGE + 1);
   localparam int THR_W     = 10;
   localparam int DIGIT_W   = 4;
   localparam int SEG_W     = 8;
   localparam int SEL_W     = 3;
   localparam int SHOWN_W   = 10;
   localparam int PHASE_W   = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_OFF_ABOVE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RELAY_ON_BELOW  = 2'd1;
   localparam logic [THR_W-1:0] RELAY_OFF_ABOVE_RESET = 10'd921;
   localparam logic [THR_W-1:0] RELAY_ON_BELOW_RESET  = 10'd820;

   // Operation codes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   // Average: sum / SAMPLES_PER_AVERAGE by reciprocal multiply
   localparam int DIV_SHIFT = 20;
   localparam int RECIP_W   = DIV_SHIFT + 1;
   localparam int DIV_RECIP = ((1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE;

   // Range selection and scaling
   localparam int LOW_FACTOR   = 50;
   localparam int LOW_PROD_W   = SUM_W + 6;
   localparam int LOW_LIMIT    = 10240;
   localparam int SCALE_W      = 12;
   localparam int SCALE_SHIFT  = 9;
   localparam int SCALE_LOW    = 2500;
   localparam int SCALE_HIGH   = 250;
   localparam int VAL_W        = SUM_W + SCALE_W - SCALE_SHIFT;

   // Decimal split: val / 100 and rem / 10 by reciprocal multiply
   localparam int HUND_SHIFT = 24;
   localparam int HUND_W     = 18;
   localparam int HUND_RECIP = ((1 << HUND_SHIFT) + 99) / 100;
   localparam int QUOT_W     = VAL_W - 6;
   localparam int REM_W      = 7;
   localparam int TENS_SHIFT = 10;
   localparam int TENS_RECIP = 103;

   // Digit selects, active low
   localparam logic [SEL_W-1:0] SEL_OFF   = 3'b111;
   localparam logic [SEL_W-1:0] SEL_HUND  = 3'b110;
   localparam logic [SEL_W-1:0] SEL_TENS  = 3'b101;
   localparam logic [SEL_W-1:0] SEL_UNITS = 3'b011;
   localparam logic [SEG_W-1:0] SEG_POINT = 8'h80;

   // Queue depths
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);
   localparam int RSP_DEPTH = 2;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic              operation;
      logic [CODE_W-1:0] sample_code;
   } req_type;

   typedef struct packed {
      logic [SEG_W-1:0]   segments;
      logic [SEL_W-1:0]   digit_enable_n;
      logic               relay;
      logic [SHOWN_W-1:0] shown_value;
   } rsp_type;

   // Classified item between front and back
   typedef struct packed {
      logic              is_tick;
      logic [CODE_W-1:0] code;
   } job_type;

   typedef struct packed {
      logic [THR_W-1:0] off_above;
      logic [THR_W-1:0] on_below;
   } thr_type;

   // Seven-segment pattern of a decimal digit, blank above nine
   function automatic logic [SEG_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
      logic [SEG_W-1:0] p;
      case (d)
         4'd0:    p = 8'h3F;
         4'd1:    p = 8'h06;
         4'd2:    p = 8'h5B;
         4'd3:    p = 8'h4F;
         4'd4:    p = 8'h66;
         4'd5:    p = 8'h6D;
         4'd6:    p = 8'h7D;
         4'd7:    p = 8'h07;
         4'd8:    p = 8'h7F;
         4'd9:    p = 8'h6F;
         default: p = '0;
      endcase
      return p;
   endfunction

endpackage

>>> design/avsv_front.sv
// Front end of the voltmeter: accepts request transactions, classifies them
// and holds them in a short job queue. Depends on avsv_pkg.
module avsv_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  avsv_pkg::req_type req_data,
   output logic              job_valid,
   output avsv_pkg::job_type job,
   input  logic              job_take
);
   import avsv_pkg::*;

   job_type              job_mem_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0] count_ff, count_in;
   logic                 push_ok;
   logic                 pop_ok;
   job_type              new_job;

   // Classify the incoming transaction
   always_comb begin
      new_job.is_tick = (req_data.operation == OP_TICK);
      new_job.code    = req_data.sample_code;
   end

   assign req_full  = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign job_valid = (count_ff != '0);
   assign job       = job_mem_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = job_take && job_valid;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + JOB_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + JOB_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + JOB_CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the classified job
   always_ff @(posedge clock) begin
      if (push_ok) begin
         job_mem_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

>>> design/avsv_back.sv
// Back end of the voltmeter: accumulates samples, averages, scales, splits
// into digits, runs the relay hysteresis and the display scan. Uses avsv_pkg.
module avsv_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   input  avsv_pkg::job_type job,
   output logic              job_take,
   input  avsv_pkg::thr_type thr,
   input  logic              out_room,
   output logic              rsp_push,
   output avsv_pkg::rsp_type rsp_item
);
   import avsv_pkg::*;

   // Sequencer steps
   localparam logic [1:0] STEP_IDLE   = 2'd0;
   localparam logic [1:0] STEP_SCALE  = 2'd1;
   localparam logic [1:0] STEP_SPLIT  = 2'd2;
   localparam logic [1:0] STEP_DIGITS = 2'd3;

   // Scan phases
   localparam logic [PHASE_W-1:0] PH_START = 2'd0;
   localparam logic [PHASE_W-1:0] PH_HUND  = 2'd1;
   localparam logic [PHASE_W-1:0] PH_TENS  = 2'd2;
   localparam logic [PHASE_W-1:0] PH_UNITS = 2'd3;

   logic [1:0]           step_ff, step_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [TALLY_W-1:0]   tally_ff, tally_in;
   logic [DIGIT_W-1:0]   hund_ff, hund_in;
   logic [DIGIT_W-1:0]   tens_ff, tens_in;
   logic [DIGIT_W-1:0]   units_ff, units_in;
   logic                 low_ff, low_in;
   logic                 relay_ff, relay_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [SEG_W-1:0]     seg_ff, seg_in;
   logic [SEL_W-1:0]     sel_ff, sel_in;
   logic [SUM_W-1:0]     avg_ff, avg_in;
   logic [VAL_W-1:0]     val_ff, val_in;
   logic [REM_W-1:0]     rem_ff, rem_in;

   logic [SUM_W-1:0]            sum_add;
   logic [TALLY_W-1:0]          tally_add;
   logic [SUM_W+RECIP_W-1:0]    div_prod;
   logic [LOW_PROD_W-1:0]       low_prod;
   logic                        low_now;
   logic [SCALE_W-1:0]          scale_k;
   logic [SUM_W+SCALE_W-1:0]    scale_prod;
   logic [VAL_W+HUND_W-1:0]     hund_prod;
   logic [QUOT_W-1:0]           quot;
   logic [QUOT_W+REM_W-1:0]     quot_x100;
   logic [REM_W+REM_W-1:0]      tens_prod;
   logic [DIGIT_W-1:0]          tens_now;
   logic [REM_W-1:0]            tens_x10;
   logic [SHOWN_W:0]            shown_sum;

   // Arithmetic of each step, one or two multiplies apiece
   always_comb begin
      sum_add    = sum_ff + SUM_W'(job.code);
      tally_add  = tally_ff + TALLY_W'(1);
      div_prod   = (SUM_W+RECIP_W)'(sum_add) * (SUM_W+RECIP_W)'(DIV_RECIP);
      low_prod   = LOW_PROD_W'(avg_ff) * LOW_PROD_W'(LOW_FACTOR);
      low_now    = (low_prod < LOW_PROD_W'(LOW_LIMIT));
      scale_k    = low_now ? SCALE_W'(SCALE_LOW) : SCALE_W'(SCALE_HIGH);
      scale_prod = (SUM_W+SCALE_W)'(avg_ff) * (SUM_W+SCALE_W)'(scale_k);
      hund_prod  = (VAL_W+HUND_W)'(val_ff) * (VAL_W+HUND_W)'(HUND_RECIP);
      quot       = hund_prod[HUND_SHIFT +: QUOT_W];
      quot_x100  = (QUOT_W+REM_W)'(quot) * (QUOT_W+REM_W)'(100);
      tens_prod  = (2*REM_W)'(rem_ff) * (2*REM_W)'(TENS_RECIP);
      tens_now   = tens_prod[TENS_SHIFT +: DIGIT_W];
      tens_x10   = REM_W'(tens_now) * REM_W'(10);
   end

   // Sequencer: take jobs, run the averaging steps, emit one result per job
   always_comb begin
      step_in  = step_ff;
      sum_in   = sum_ff;
      tally_in = tally_ff;
      hund_in  = hund_ff;
      tens_in  = tens_ff;
      units_in = units_ff;
      low_in   = low_ff;
      relay_in = relay_ff;
      phase_in = phase_ff;
      seg_in   = seg_ff;
      sel_in   = sel_ff;
      avg_in   = avg_ff;
      val_in   = val_ff;
      rem_in   = rem_ff;
      job_take = 1'b0;
      rsp_push = 1'b0;
      unique case (step_ff)
         STEP_IDLE: begin
            if (job_valid && out_room) begin
               job_take = 1'b1;
               if (job.is_tick) begin
                  rsp_push = 1'b1;
                  unique case (phase_ff)
                     PH_START, PH_UNITS: begin
                        phase_in = PH_HUND;
                        sel_in   = SEL_HUND;
                        seg_in   = glyph(hund_ff) | (low_ff ? SEG_POINT : '0);
                     end
                     PH_HUND: begin
                        phase_in = PH_TENS;
                        sel_in   = SEL_TENS;
                        seg_in   = glyph(tens_ff) | (low_ff ? '0 : SEG_POINT);
                     end
                     PH_TENS: begin
                        phase_in = PH_UNITS;
                        sel_in   = SEL_UNITS;
                        seg_in   = glyph(units_ff);
                     end
                     default: begin
                        phase_in = PH_HUND;
                     end
                  endcase
               end else if (tally_add >= TALLY_W'(SAMPLES_PER_AVERAGE)) begin
                  // Block complete: form the average, clear the accumulator
                  avg_in   = div_prod[DIV_SHIFT +: SUM_W];
                  sum_in   = '0;
                  tally_in = '0;
                  step_in  = STEP_SCALE;
               end else begin
                  rsp_push = 1'b1;
                  sum_in   = sum_add;
                  tally_in = tally_add;
               end
            end
         end
         STEP_SCALE: begin
            // Clear first, then set, so set wins on overlapping thresholds
            if (avg_ff > SUM_W'(thr.off_above)) begin
               relay_in = 1'b0;
            end
            if (avg_ff < SUM_W'(thr.on_below)) begin
               relay_in = 1'b1;
            end
            low_in  = low_now;
            val_in  = scale_prod[SCALE_SHIFT +: VAL_W];
            step_in = STEP_SPLIT;
         end
         STEP_SPLIT: begin
            hund_in = quot[DIGIT_W-1:0];
            rem_in  = REM_W'(VAL_W'(val_ff) - VAL_W'(quot_x100));
            step_in = STEP_DIGITS;
         end
         STEP_DIGITS: begin
            tens_in  = tens_now;
            units_in = DIGIT_W'(rem_ff - tens_x10);
            rsp_push = 1'b1;
            step_in  = STEP_IDLE;
         end
         default: begin
            step_in = STEP_IDLE;
         end
      endcase
   end

   // Result from the updated state
   always_comb begin
      shown_sum = (SHOWN_W+1)'(hund_in) * (SHOWN_W+1)'(100)
                + (SHOWN_W+1)'(tens_in) * (SHOWN_W+1)'(10)
                + (SHOWN_W+1)'(units_in);
      rsp_item.segments       = seg_in;
      rsp_item.digit_enable_n = sel_in;
      rsp_item.relay          = relay_in;
      rsp_item.shown_value    = shown_sum[SHOWN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_IDLE;
         sum_ff   <= '0;
         tally_ff <= '0;
         hund_ff  <= '0;
         tens_ff  <= '0;
         units_ff <= '0;
         low_ff   <= 1'b1;
         relay_ff <= 1'b0;
         phase_ff <= PH_START;
         seg_ff   <= '0;
         sel_ff   <= SEL_OFF;
      end else begin
         step_ff  <= step_in;
         sum_ff   <= sum_in;
         tally_ff <= tally_in;
         hund_ff  <= hund_in;
         tens_ff  <= tens_in;
         units_ff <= units_in;
         low_ff   <= low_in;
         relay_ff <= relay_in;
         phase_ff <= phase_in;
         seg_ff   <= seg_in;
         sel_ff   <= sel_in;
      end
   end

   // Intermediate values of the averaging steps
   always_ff @(posedge clock) begin
      avg_ff <= avg_in;
      val_ff <= val_in;
      rem_ff <= rem_in;
   end

endmodule

>>> design/avsv_rsp_queue.sv
// Result queue of the voltmeter: registers finished results until the
// receiver pops them. Depends on avsv_pkg.
module avsv_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_push,
   input  avsv_pkg::rsp_type rsp_item,
   output logic              out_room,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output avsv_pkg::rsp_type rsp_data
);
   import avsv_pkg::*;

   rsp_type              entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop_ok;

   assign out_room  = (count_ff != RSP_CNT_W'(RSP_DEPTH));
   assign rsp_empty = (count_ff == '0);
   assign rsp_data  = entry_ff[rd_ptr_ff];
   assign pop_ok    = rsp_pop && !rsp_empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = rsp_push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (rsp_push && !pop_ok) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (pop_ok && !rsp_push) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Hold the result
   always_ff @(posedge clock) begin
      if (rsp_push) begin
         entry_ff[wr_ptr_ff] <= rsp_item;
      end
   end

endmodule

>>> design/averaging_voltmeter_seven_segment.sv
// Averaging voltmeter with relay hysteresis and a three-digit multiplexed
// seven-segment display. Top level; uses avsv_pkg, avsv_front, avsv_back
// and avsv_rsp_queue.
//
// - Requests: push a transaction while full is low. Operation 0 adds a
//   converter code; every tenth sample ends a block and updates the shown
//   value, range and relay. Operation 1 advances the digit scan.
// - Results: one per request, in order, on the ports while empty is low and
//   removed with pop: segment and select latches, relay and shown value.
// - Threshold registers: csr_valid/csr_index/csr_data, always ready; write
//   only while nothing is in flight. Data keeps 10 bits, indexes above 1 drop.
// - Path: a request is registered in the job queue and its result in the
//   result queue; a block-ending sample also runs the scale, split and
//   digit steps between them.
// - Throughput: one transaction per cycle while full is low; the four-entry
//   job queue buffers transactions while a block-ending sample holds the back end.
// - A stalled receiver fills the two-entry result queue, the back end stops
//   taking jobs and full rises once the job queue is full.
// - Reset empties both queues, restores the register defaults and sets all
//   digits off with the low range selected.
module averaging_voltmeter_seven_segment (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  avsv_pkg::req_type                    req_data,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output avsv_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [avsv_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [avsv_pkg::CSR_DATA_W-1:0]      csr_data
);
   import avsv_pkg::*;

   thr_type thr_ff, thr_in;
   logic    job_valid;
   job_type job;
   logic    job_take;
   logic    out_room;
   logic    rsp_push;
   rsp_type rsp_item;

   assign csr_ready = 1'b1;

   // Decode threshold register writes
   always_comb begin
      thr_in = thr_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RELAY_OFF_ABOVE: thr_in.off_above = csr_data[THR_W-1:0];
            CSR_RELAY_ON_BELOW:  thr_in.on_below  = csr_data[THR_W-1:0];
            default:             thr_in = thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.off_above <= RELAY_OFF_ABOVE_RESET;
         thr_ff.on_below  <= RELAY_ON_BELOW_RESET;
      end else begin
         thr_ff <= thr_in;
      end
   end

   avsv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take)
   );

   avsv_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (job),
      .job_take  (job_take),
      .thr       (thr_ff),
      .out_room  (out_room),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item)
   );

   avsv_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .rsp_push  (rsp_push),
      .rsp_item  (rsp_item),
      .out_room  (out_room),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // Never write a result into a full result queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> out_room)
      else $error("result pushed into full queue");

   // The back end only takes a job that is waiting
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      job_take |-> job_valid)
      else $error("job taken from empty queue");

   // Reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // At most one digit is ever enabled
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.digit_enable_n == SEL_OFF ||
                      rsp_data.digit_enable_n == SEL_HUND ||
                      rsp_data.digit_enable_n == SEL_TENS ||
                      rsp_data.digit_enable_n == SEL_UNITS))
      else $error("illegal digit select");

endmodule

>>> bench/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for averaging_voltmeter_seven_segment: queue-style driver and monitor
// around a cycle-free predictor of averaging, scaling, relay hysteresis and digit scan.
// Depends on avsv_pkg and the block's top level only.
module tb;
   import avsv_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_ITEMS    = 80;

   // Scaling of the average: volts = avg * 50 / 1024
   localparam int unsigned VOLT_NUMERATOR = 50;
   localparam int unsigned RANGE_LIMIT    = 10240;
   localparam int unsigned CENTI_SCALE    = 2500;
   localparam int unsigned DECI_SCALE     = 250;
   localparam int unsigned FRACTION_SHIFT = 9;

   // Register indexes with no register behind them
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_2 = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_3 = 2'd3;

   // Segment patterns a..g for digits 0..9
   localparam logic [9:0][SEG_W-1:0] DIGIT_FONT = {
      8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D, 8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F
   };

   typedef enum logic [1:0] {SCAN_OFF, SCAN_HUNDREDS, SCAN_TENS, SCAN_UNITS} scan_e;
   typedef enum logic [1:0] {POP_EVERY, POP_COIN, POP_SPARSE} pop_style_e;

   typedef struct {
      req_type item;
      bit      drain_first;
   } stim_entry;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_push  = 1'b0;
   logic                   req_full;
   req_type                req_data  = '0;
   logic                   rsp_empty;
   logic                   rsp_pop   = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data  = '0;

   averaging_voltmeter_seven_segment DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #4 clock = ~clock;

   // Predictor state and thresholds
   logic [THR_W-1:0]   limit_off_above = RELAY_OFF_ABOVE_RESET;
   logic [THR_W-1:0]   limit_on_below  = RELAY_ON_BELOW_RESET;
   logic [SUM_W-1:0]   running_sum     = '0;
   int unsigned        running_count   = 0;
   int unsigned        hundreds = 0, tens = 0, units = 0;
   logic               low_range       = 1'b1;
   logic               relay_on        = 1'b0;
   scan_e              scan            = SCAN_OFF;
   logic [SEG_W-1:0]   seg_latch       = '0;
   logic [SEL_W-1:0]   sel_latch       = SEL_OFF;

   rsp_type   expected_readings[$];
   stim_entry stimulus_items[$];

   int error_count = 0, results_checked = 0, items_accepted = 0;
   int samples_seen = 0, ticks_seen = 0, averages_done = 0, csr_writes = 0;
   int gen_tally = 0, gen_level = 0, gen_spread = 0;
   int burst_left = 0, gap_left = 0, pattern_left = 0, idle_cycles = 0;
   pop_style_e pop_mode = POP_EVERY;

   function automatic logic [SEG_W-1:0] digit_pattern(input int unsigned d);
      return (d < 10) ? DIGIT_FONT[d] : '0;
   endfunction

   // Advance the predictor by one accepted transaction and store the reading it gives
   task automatic predict_display(input req_type item);
      int unsigned avg;
      int unsigned val;
      rsp_type     reading;
      if (item.operation == OP_SAMPLE) begin
         samples_seen++;
         running_sum = running_sum + item.sample_code;
         running_count++;
         if (running_count >= SAMPLES_PER_AVERAGE) begin
            avg = running_sum / SAMPLES_PER_AVERAGE;
            // clear first, then set: inconsistent limits leave the relay set
            if (avg > limit_off_above) relay_on = 1'b0;
            if (avg < limit_on_below) relay_on = 1'b1;
            low_range = (avg * VOLT_NUMERATOR < RANGE_LIMIT);
            val = low_range ? (avg * CENTI_SCALE) >> FRACTION_SHIFT
                            : (avg * DECI_SCALE) >> FRACTION_SHIFT;
            hundreds = val / 100;
            tens = (val % 100) / 10;
            units = val % 10;
            running_sum = '0;
            running_count = 0;
            averages_done++;
         end
      end else begin
         ticks_seen++;
         case (scan)
            SCAN_HUNDREDS: scan = SCAN_TENS;
            SCAN_TENS:     scan = SCAN_UNITS;
            default:       scan = SCAN_HUNDREDS;
         endcase
         case (scan)
            SCAN_HUNDREDS: begin
               sel_latch = SEL_HUND;
               seg_latch = digit_pattern(hundreds) | (low_range ? SEG_POINT : '0);
            end
            SCAN_TENS: begin
               sel_latch = SEL_TENS;
               seg_latch = digit_pattern(tens) | (low_range ? '0 : SEG_POINT);
            end
            default: begin
               sel_latch = SEL_UNITS;
               seg_latch = digit_pattern(units);
            end
         endcase
      end
      reading.segments       = seg_latch;
      reading.digit_enable_n = sel_latch;
      reading.relay          = relay_on;
      reading.shown_value    = SHOWN_W'(hundreds * 100 + tens * 10 + units);
      expected_readings.push_back(reading);
   endtask

   // Compare one result transaction with the oldest stored reading
   task automatic check_reading(input rsp_type got);
      rsp_type want;
      results_checked++;
      if (expected_readings.size() == 0) begin
         $error("unexpected result transaction: %p", got);
         error_count++;
      end else begin
         want = expected_readings.pop_front();
         if (got.segments !== want.segments) begin
            $error("segments: expected %h, got %h", want.segments, got.segments);
            error_count++;
         end
         if (got.digit_enable_n !== want.digit_enable_n) begin
            $error("digit_enable_n: expected %b, got %b",
                   want.digit_enable_n, got.digit_enable_n);
            error_count++;
         end
         if (got.relay !== want.relay) begin
            $error("relay: expected %b, got %b", want.relay, got.relay);
            error_count++;
         end
         if (got.shown_value !== want.shown_value) begin
            $error("shown_value: expected %0d, got %0d", want.shown_value, got.shown_value);
            error_count++;
         end
      end
   endtask

   // Driver: send in bursts with random gaps, hold while full
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_display(req_data);
            items_accepted++;
         end
         if (req_push && req_full) begin
            // hold the transaction until taken
         end else if (stimulus_items.size() == 0 || gap_left > 0 ||
                      (stimulus_items[0].drain_first && expected_readings.size() != 0)) begin
            req_push <= 1'b0;
            if (gap_left > 0) gap_left--;
         end else begin
            req_push <= 1'b1;
            req_data <= stimulus_items[0].item;
            stimulus_items.pop_front();
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 23);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            end
         end
      end
   end

   // Monitor: check every result, pop on a pattern that changes now and then
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_reading(rsp_data);
         if (pattern_left == 0) begin
            pop_mode = pop_style_e'($urandom_range(0, 2));
            pattern_left = $urandom_range(8, 64);
         end
         pattern_left--;
         case (pop_mode)
            POP_EVERY: rsp_pop <= 1'b1;
            POP_COIN:  rsp_pop <= ($urandom_range(0, 1) == 1);
            default:   rsp_pop <= (pattern_left % 6 == 0);
         endcase
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   task automatic queue_item(input logic op, input int code, input bit drain);
      stim_entry e;
      e.item.operation   = op;
      e.item.sample_code = CODE_W'(code);
      e.drain_first      = drain;
      stimulus_items.push_back(e);
      if (op == OP_SAMPLE) gen_tally = (gen_tally + 1) % SAMPLES_PER_AVERAGE;
   endtask

   // Random mix: mostly samples grouped around a level chosen per averaging block
   task automatic queue_random_phase(input int count);
      int code;
      int pick;
      bit drain;
      for (int n = 0; n < count; n++) begin
         drain = (n == count / 2) || ($urandom_range(0, 79) == 0);
         if ($urandom_range(0, 3) == 0) begin
            queue_item(OP_TICK, $urandom_range(0, 1023), drain);
         end else begin
            if (gen_tally == 0) begin
               pick = $urandom_range(0, 7);
               case (pick)
                  0:       gen_level = 0;
                  1:       gen_level = 1023;
                  2:       gen_level = 204 + $urandom_range(0, 1);
                  3:       gen_level = int'(limit_off_above) + $urandom_range(0, 2) - 1;
                  4:       gen_level = int'(limit_on_below) + $urandom_range(0, 2) - 1;
                  default: gen_level = $urandom_range(0, 1023);
               endcase
               gen_spread = $urandom_range(0, 2);
            end
            case (gen_spread)
               0:       code = gen_level;
               1:       code = gen_level + $urandom_range(0, 8) - 4;
               default: code = $urandom_range(0, 1023);
            endcase
            if (code < 0) code = 0;
            if (code > 1023) code = 1023;
            queue_item(OP_SAMPLE, code, drain);
         end
      end
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= {6'($urandom), 10'(value)};
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_RELAY_OFF_ABOVE) limit_off_above = THR_W'(value);
      else if (idx == CSR_RELAY_ON_BELOW) limit_on_below = THR_W'(value);
      csr_writes++;
   endtask

   // Wait until nothing is queued, in flight or expected, then let the block settle
   task automatic wait_drained();
      do @(posedge clock);
      while (!(stimulus_items.size() == 0 && !req_push && expected_readings.size() == 0));
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int off_above, input int on_below);
      write_register(CSR_RELAY_OFF_ABOVE, off_above);
      write_register(CSR_RELAY_ON_BELOW, on_below);
      queue_random_phase(PHASE_ITEMS);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: first tick from reset with a code that must be ignored
      queue_item(OP_TICK, 1023, 1'b0);
      // Zero-scale block sets the relay, low range, hundreds point lit
      repeat (SAMPLES_PER_AVERAGE) queue_item(OP_SAMPLE, 0, 1'b0);
      repeat (2) queue_item(OP_TICK, 0, 1'b0);
      // Full-scale block clears the relay and moves to the high range
      repeat (SAMPLES_PER_AVERAGE) queue_item(OP_SAMPLE, 1023, 1'b0);
      // Wrap the scan from units back to hundreds
      repeat (3) queue_item(OP_TICK, 0, 1'b0);
      wait_drained();

      // Writes to unused indexes must change nothing
      write_register(CSR_UNUSED_2, 1023);
      write_register(CSR_UNUSED_3, 0);
      // Limits at the extremes: relay frozen
      run_phase(1023, 0);
      // Both conditions true for mid-scale averages
      run_phase(0, 1023);
      run_phase(300, 200);
      repeat (2) run_phase($urandom_range(0, 1023), $urandom_range(0, 1023));
      run_phase(RELAY_OFF_ABOVE_RESET, RELAY_ON_BELOW_RESET);

      $display("Checked %0d results of %0d transactions: %0d samples, %0d ticks.",
               results_checked, items_accepted, samples_seen, ticks_seen);
      $display("Completed %0d averages across %0d register writes, %0d mismatches.",
               averages_done, csr_writes, error_count);
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

>>> files.f
design/avsv_pkg.sv
design/avsv_front.sv
design/avsv_back.sv
design/avsv_rsp_queue.sv
design/averaging_voltmeter_seven_segment.sv
bench/tb.sv
